>>> sv/winch_motor_pid_drive_macros.svh
// Assertion macros for the winch motor drive checker.
// No dependencies; included by the checker file only.
`ifndef WINCH_MOTOR_PID_DRIVE_MACROS_SVH
`define WINCH_MOTOR_PID_DRIVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WMPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/wmpd_pkg.sv
// Shared types, constants and codes for the winch motor drive.
// No dependencies; imported by every module of the block.
`default_nettype none

package wmpd_pkg;

	// Default parameter values.
	localparam int WMPD_COUNT_WIDTH = 32;
	localparam int WMPD_FRAC_BITS   = 8;

	// Fixed field and datapath widths.
	localparam int WORK_W     = 72;
	localparam int MAG_W      = 63;
	localparam int PROD_W     = 95;
	localparam int STATE_W    = 48;
	localparam int DESIRED_W  = 40;
	localparam int GAIN_W     = 20;
	localparam int SCALE_W    = 32;
	localparam int CODE_W     = 12;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int Q30_SHIFT  = 30;
	localparam int SCALE_FRAC = 40;

	typedef logic signed [WORK_W-1:0] work_t;

	// Saturation limit of the saturating products (MUL_SAT) and of the saturated sums.
	localparam work_t WORK_LIM = work_t'(64'h3FFF_FFFF_FFFF_FFFF);

	// Biquad coefficients in Q30; the second feedback term is subtracted.
	localparam logic [SCALE_W-1:0] CB0 = 32'd42016;
	localparam logic [SCALE_W-1:0] CB1 = 32'd84031;
	localparam logic [SCALE_W-1:0] CB2 = 32'd42016;
	localparam logic [SCALE_W-1:0] CA1 = 32'd2128401927;
	localparam logic [SCALE_W-1:0] CA2 = 32'd1054828166;

	// Tick rate for differences, and the half rate of the speed estimate.
	localparam logic [SCALE_W-1:0] RATE_GAIN = 32'd1000;
	localparam int VEL_BASE = 500;

	// Register reset values.
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 20'd150000;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 20'd5;
	localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 20'd10000;
	localparam logic [SCALE_W-1:0] RST_DRIVE_SCALE = 32'd12588000;
	localparam logic [CODE_W-1:0]  RST_MID_CODE    = 12'd2048;
	localparam logic [CODE_W-1:0]  RST_MIN_CODE    = 12'd163;
	localparam logic [CODE_W-1:0]  RST_MAX_CODE    = 12'd3932;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN,
		REG_INTEG_GAIN,
		REG_DERIV_GAIN,
		REG_DRIVE_SCALE,
		REG_MID_CODE,
		REG_MIN_CODE,
		REG_MAX_CODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_SAT,
		MUL_Q30,
		MUL_SCALE
	} mul_op_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [SCALE_W-1:0] drive_scale;
		logic [CODE_W-1:0]  mid_code;
		logic [CODE_W-1:0]  min_code;
		logic [CODE_W-1:0]  max_code;
	} cfg_t;

	typedef struct packed {
		logic               start;
		mul_op_t            op;
		work_t              a;
		logic [SCALE_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		work_t result;
	} mul_rsp_t;

	typedef struct packed {
		logic [CODE_W-1:0]           dac_code;
		logic                        clamped_low;
		logic                        clamped_high;
		logic signed [DESIRED_W-1:0] filtered_velocity;
	} result_t;

endpackage

`default_nettype wire

>>> sv/winch_motor_pid_drive.sv
// Top level of the winch motor drive: configuration registers, request
// handshake and result register. Depends on wmpd_pkg, wmpd_mul, wmpd_core.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  config   | cfg_write               | cfg_index, cfg_data
//  request  | in_valid / in_ready     | measured_count, desired_count, prime
//  result   | out_valid / out_ready   | dac_code, clamped_low, clamped_high,
//           |                         | filtered_velocity
//
// A control request sends twelve products one at a time through the shared
// multiply unit, after setup and before the clamp; a prime request skips them.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the core until the output register is free, and the output register holds
// while out_ready is low. Reset returns the configuration registers to defaults
// and clears the controller history.
`default_nettype none

module winch_motor_pid_drive
	import wmpd_pkg::*;
#(
	parameter int COUNT_WIDTH = WMPD_COUNT_WIDTH,
	parameter int FRAC_BITS   = WMPD_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COUNT_WIDTH-1:0] measured_count,
	input  logic signed [DESIRED_W-1:0]   desired_count,
	input  logic                          prime,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [CODE_W-1:0]             dac_code,
	output logic                          clamped_low,
	output logic                          clamped_high,
	output logic signed [DESIRED_W-1:0]   filtered_velocity
);

	cfg_t     cfg_q;
	logic     out_valid_q;
	result_t  out_res_q;
	logic     core_idle;
	logic     core_valid;
	logic     core_take;
	result_t  core_res;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	// Configuration registers, masked to their widths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= RST_PROP_GAIN;
			cfg_q.integ_gain  <= RST_INTEG_GAIN;
			cfg_q.deriv_gain  <= RST_DERIV_GAIN;
			cfg_q.drive_scale <= RST_DRIVE_SCALE;
			cfg_q.mid_code    <= RST_MID_CODE;
			cfg_q.min_code    <= RST_MIN_CODE;
			cfg_q.max_code    <= RST_MAX_CODE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_SCALE: cfg_q.drive_scale <= cfg_data[SCALE_W-1:0];
				REG_MID_CODE:    cfg_q.mid_code    <= cfg_data[CODE_W-1:0];
				REG_MIN_CODE:    cfg_q.min_code    <= cfg_data[CODE_W-1:0];
				REG_MAX_CODE:    cfg_q.max_code    <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Result register: loads a finished result whenever it is empty or being emptied.
	assign core_take = core_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take) begin
			out_res_q <= core_res;
		end
	end

	wmpd_core #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (in_valid && core_idle),
		.measured_count (measured_count),
		.desired_count  (desired_count),
		.prime          (prime),
		.cfg            (cfg_q),
		.idle           (core_idle),
		.res_valid      (core_valid),
		.res_take       (core_take),
		.res            (core_res),
		.mul_req        (mul_req),
		.mul_rsp        (mul_rsp)
	);

	wmpd_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign in_ready          = core_idle;
	assign out_valid         = out_valid_q;
	assign dac_code          = out_res_q.dac_code;
	assign clamped_low       = out_res_q.clamped_low;
	assign clamped_high      = out_res_q.clamped_high;
	assign filtered_velocity = out_res_q.filtered_velocity;

endmodule

`default_nettype wire

>>> sv/wmpd_mul.sv
// Shared multiply unit: 63-bit magnitude times 32-bit factor in two halves,
// then saturation, Q30 rounding or floor scaling. Depends on wmpd_pkg.
`default_nettype none

module wmpd_mul
	import wmpd_pkg::*;
#(
	parameter int FRAC_BITS = WMPD_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int SC_SHIFT = SCALE_FRAC + FRAC_BITS;
	localparam logic [PROD_W-1:0] SC_MASK = (PROD_W'(1) << SC_SHIFT) - PROD_W'(1);
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (Q30_SHIFT - 1);

	typedef enum logic [2:0] {
		M_IDLE,
		M_LO,
		M_HI,
		M_SUM,
		M_POST
	} mstate_t;

	mstate_t            state_q;
	logic               done_q;
	work_t              result_q;
	logic [MAG_W-1:0]   ma_q;
	logic [SCALE_W-1:0] mb_q;
	logic               neg_q;
	mul_op_t            op_q;
	logic [63:0]        pp_lo_q;
	logic [62:0]        pp_hi_q;
	logic [PROD_W-1:0]  prod_q;

	logic [PROD_W-1:0]  rnd;
	logic [WORK_W-1:0]  mag_r;
	logic               extra;
	work_t              post;

	// Finish the product: clamp, round or floor-scale the magnitude, then sign it.
	always_comb begin
		rnd   = prod_q + RND_HALF;
		extra = 1'b0;
		case (op_q)
			MUL_SAT: begin
				mag_r = (prod_q > PROD_W'(WORK_LIM)) ? WORK_W'(WORK_LIM) : WORK_W'(prod_q);
			end
			MUL_Q30: begin
				mag_r = WORK_W'(rnd >> Q30_SHIFT);
			end
			MUL_SCALE: begin
				mag_r = WORK_W'(prod_q >> SC_SHIFT);
				extra = |(prod_q & SC_MASK);
			end
			default: begin
				mag_r = '0;
			end
		endcase
		post = neg_q ? (-work_t'(mag_r) - work_t'(extra)) : work_t'(mag_r);
	end

	// Sequencer of the unit and its registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_LO;
					end
				end
				M_LO:   state_q <= M_HI;
				M_HI:   state_q <= M_SUM;
				M_SUM:  state_q <= M_POST;
				M_POST: begin
					result_q <= post;
					done_q   <= 1'b1;
					state_q  <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// Operand capture and the two partial products.
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && req.start) begin
			ma_q  <= MAG_W'(req.a[WORK_W-1] ? -req.a : req.a);
			mb_q  <= req.b;
			neg_q <= req.a[WORK_W-1];
			op_q  <= req.op;
		end
		if (state_q == M_LO) begin
			pp_lo_q <= ma_q[31:0] * mb_q;
		end
		if (state_q == M_HI) begin
			pp_hi_q <= ma_q[MAG_W-1:32] * mb_q;
		end
		if (state_q == M_SUM) begin
			prod_q <= {pp_hi_q, 32'b0} + PROD_W'(pp_lo_q);
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

`default_nettype wire

>>> sv/wmpd_core.sv
// Control sequencer and datapath registers of the drive: speed estimate, biquad,
// PID terms and DAC clamp, all products through wmpd_mul. Depends on wmpd_pkg.
`default_nettype none

module wmpd_core
	import wmpd_pkg::*;
#(
	parameter int COUNT_WIDTH = WMPD_COUNT_WIDTH,
	parameter int FRAC_BITS   = WMPD_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COUNT_WIDTH-1:0] measured_count,
	input  logic signed [DESIRED_W-1:0]   desired_count,
	input  logic                          prime,
	input  cfg_t                          cfg,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_take,
	output result_t                       res,
	output mul_req_t                      mul_req,
	input  mul_rsp_t                      mul_rsp
);

	localparam logic [SCALE_W-1:0] VEL_GAIN = SCALE_W'(VEL_BASE << FRAC_BITS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP1,
		S_PREP2,
		S_ISSUE,
		S_WAIT,
		S_DIFF,
		S_ISUM,
		S_CLAMP,
		S_HOLD
	} state_t;

	typedef enum logic [3:0] {
		OP_V,
		OP_B0,
		OP_B1,
		OP_B2,
		OP_A1,
		OP_A2,
		OP_DV,
		OP_DA,
		OP_P,
		OP_D,
		OP_I,
		OP_SC
	} op_t;

	function automatic work_t sat_lim(input work_t x);
		if (x > WORK_LIM) return WORK_LIM;
		if (x < -WORK_LIM) return -WORK_LIM;
		return x;
	endfunction

	function automatic work_t sat_bits(input work_t x, input int unsigned bits);
		work_t hi;
		work_t lo;
		hi = (work_t'(1) <<< (bits - 1)) - work_t'(1);
		lo = -hi - work_t'(1);
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	state_t  state_q;
	op_t     op_q;
	result_t res_q;

	logic signed [COUNT_WIDTH-1:0] mc_q, pc1_q, pc2_q;
	logic signed [DESIRED_W-1:0]   dc_q, pdc_q;
	logic                          prime_q;
	logic signed [STATE_W-1:0]     pdv_q, integ_q, fi1_q, fi2_q, fo1_q, fo2_q;
	logic signed [STATE_W-1:0]     vraw_q, fo_q, dv_q, it_q;
	work_t m8_q, e_q, vpre_q, ddc_q, ddv_q, dfo_q, facc_q, acc_q, code_q;

	work_t r;
	work_t mcw;
	work_t lo_bound, hi_bound;
	logic  below, above;

	assign r        = mul_rsp.result;
	assign mcw      = work_t'(mc_q);
	assign lo_bound = work_t'({1'b0, cfg.min_code});
	assign hi_bound = work_t'({1'b0, cfg.max_code});
	assign below    = code_q < lo_bound;
	assign above    = code_q > hi_bound;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_req.start = (state_q == S_ISSUE);
		mul_req.op    = MUL_SAT;
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (op_q)
			OP_V:  begin mul_req.a = vpre_q;           mul_req.b = VEL_GAIN;  end
			OP_B0: begin mul_req.a = work_t'(vraw_q);  mul_req.b = CB0;
				mul_req.op = MUL_Q30; end
			OP_B1: begin mul_req.a = work_t'(fi1_q);   mul_req.b = CB1;
				mul_req.op = MUL_Q30; end
			OP_B2: begin mul_req.a = work_t'(fi2_q);   mul_req.b = CB2;
				mul_req.op = MUL_Q30; end
			OP_A1: begin mul_req.a = work_t'(fo1_q);   mul_req.b = CA1;
				mul_req.op = MUL_Q30; end
			OP_A2: begin mul_req.a = work_t'(fo2_q);   mul_req.b = CA2;
				mul_req.op = MUL_Q30; end
			OP_DV: begin mul_req.a = ddc_q;            mul_req.b = RATE_GAIN; end
			OP_DA: begin mul_req.a = ddv_q;            mul_req.b = RATE_GAIN; end
			OP_P:  begin mul_req.a = e_q;  mul_req.b = SCALE_W'(cfg.prop_gain);  end
			OP_D:  begin mul_req.a = dfo_q; mul_req.b = SCALE_W'(cfg.deriv_gain); end
			OP_I:  begin mul_req.a = e_q;  mul_req.b = SCALE_W'(cfg.integ_gain); end
			OP_SC: begin mul_req.a = acc_q; mul_req.b = cfg.drive_scale;
				mul_req.op = MUL_SCALE; end
			default: begin mul_req.a = '0; end
		endcase
	end

	// Sequencer: prepare; unless prime, 12 products+writebacks, clamp; hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_V;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREP1;
					end
				end
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: begin
					if (prime_q) begin
						res_q.dac_code          <= cfg.mid_code;
						res_q.clamped_low       <= 1'b0;
						res_q.clamped_high      <= 1'b0;
						res_q.filtered_velocity <= '0;
						state_q                 <= S_HOLD;
					end else begin
						op_q    <= OP_V;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (mul_rsp.done) begin
						unique case (op_q)
							OP_DV: begin
								op_q    <= OP_DA;
								state_q <= S_DIFF;
							end
							OP_I: begin
								op_q    <= OP_SC;
								state_q <= S_ISUM;
							end
							OP_SC: state_q <= S_CLAMP;
							default: begin
								op_q    <= op_t'(op_q + 4'd1);
								state_q <= S_ISSUE;
							end
						endcase
					end
				end
				S_DIFF:  state_q <= S_ISSUE;
				S_ISUM:  state_q <= S_ISSUE;
				S_CLAMP: begin
					// Low bound is tested first, so crossed bounds favor the minimum.
					res_q.clamped_low  <= below;
					res_q.clamped_high <= !below && above;
					if (below) begin
						res_q.dac_code <= cfg.min_code;
					end else if (above) begin
						res_q.dac_code <= cfg.max_code;
					end else begin
						res_q.dac_code <= code_q[CODE_W-1:0];
					end
					res_q.filtered_velocity <=
						DESIRED_W'(sat_bits(work_t'(fo_q), DESIRED_W));
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Controller history, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc1_q   <= '0;
			pc2_q   <= '0;
			pdc_q   <= '0;
			pdv_q   <= '0;
			integ_q <= '0;
			fi1_q   <= '0;
			fi2_q   <= '0;
			fo1_q   <= '0;
			fo2_q   <= '0;
		end else if (state_q == S_PREP2 && prime_q) begin
			pc1_q <= mc_q;
			pc2_q <= mc_q;
			pdc_q <= DESIRED_W'(sat_bits(m8_q, DESIRED_W));
		end else if (state_q == S_CLAMP) begin
			pc2_q   <= pc1_q;
			pc1_q   <= mc_q;
			fi2_q   <= fi1_q;
			fi1_q   <= vraw_q;
			fo2_q   <= fo1_q;
			fo1_q   <= fo_q;
			pdc_q   <= dc_q;
			pdv_q   <= dv_q;
			integ_q <= it_q;
		end
	end

	// Request capture and working values.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mc_q    <= measured_count;
			dc_q    <= desired_count;
			prime_q <= prime;
		end
		if (state_q == S_PREP1) begin
			m8_q   <= sat_lim(mcw <<< FRAC_BITS);
			vpre_q <= (mcw <<< 1) + mcw - (work_t'(pc1_q) <<< 2) + work_t'(pc2_q);
			ddc_q  <= work_t'(dc_q) - work_t'(pdc_q);
		end
		if (state_q == S_PREP2) begin
			e_q <= sat_lim(work_t'(dc_q) - m8_q);
		end
		if (state_q == S_DIFF) begin
			ddv_q <= work_t'(dv_q) - work_t'(pdv_q);
			dfo_q <= work_t'(dv_q) - work_t'(fo_q);
		end
		if (state_q == S_ISUM) begin
			acc_q <= sat_lim(acc_q + work_t'(it_q));
		end
		if (state_q == S_WAIT && mul_rsp.done) begin
			case (op_q)
				OP_V:  vraw_q <= STATE_W'(sat_bits(r, STATE_W));
				OP_B0: facc_q <= r;
				OP_B1, OP_B2, OP_A1: facc_q <= facc_q + r;
				OP_A2: fo_q   <= STATE_W'(sat_bits(facc_q - r, STATE_W));
				OP_DV: dv_q   <= STATE_W'(sat_bits(r, STATE_W));
				OP_DA: acc_q  <= r;
				OP_P, OP_D: acc_q <= sat_lim(acc_q + r);
				OP_I:  it_q   <= STATE_W'(sat_bits(r + work_t'(integ_q), STATE_W));
				OP_SC: code_q <= work_t'({1'b0, cfg.mid_code}) + r;
				default: ;
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_HOLD);
	assign res       = res_q;

endmodule

`default_nettype wire

>>> sv/wmpd_chk.sv
// Port-level checker for the winch motor drive, bound to the top level.
// Depends on wmpd_pkg and winch_motor_pid_drive_macros.svh.
`default_nettype none
`include "winch_motor_pid_drive_macros.svh"

module wmpd_chk
	import wmpd_pkg::*;
(
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [CODE_W-1:0]           dac_code,
	input wire logic                        clamped_low,
	input wire logic                        clamped_high,
	input wire logic signed [DESIRED_W-1:0] filtered_velocity
);

	// Only one clamp direction can apply to a code.
	`WMPD_ASSERT_IMP(a_one_clamp, clk, arst_n, out_valid, !(clamped_low && clamped_high), "both clamp flags set")

	// One request at a time: the block is busy right after taking one.
	`WMPD_ASSERT_NXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready, "ready stayed high after a request")

	// No result can appear in the cycle right after a request is taken.
	`WMPD_ASSERT_NXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after request")

	// A stalled result stays valid and holds its DAC code and filtered velocity.
	`WMPD_ASSERT_NXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(dac_code) && $stable(filtered_velocity), "stalled result changed")

endmodule

bind winch_motor_pid_drive wmpd_chk u_chk (.*);

`default_nettype wire
